// ===== sv/pisl_pkg.sv =====
// ----------------------------------------------------------------------------
// pisl_pkg
// Shared types and constants for the PI speed loop with anti-windup.
// ----------------------------------------------------------------------------
package pisl_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int INTEG_W     = 48;
    localparam int ERR_W       = 17;
    localparam int PROD_W      = 33;
    localparam int SUM_W       = 49;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT   = 4'd0,
        REG_PROP_GAIN  = 4'd1,
        REG_INTEG_GAIN = 4'd2,
        REG_DUTY_LIMIT = 4'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CS_NONE  = 2'd0,
        CS_HIGH  = 2'd1,
        CS_LOW   = 2'd2,
        CS_FAULT = 2'd3
    } clamp_state_t;

    localparam logic signed [15:0] SETPOINT_RST   = 16'sd0;
    localparam logic        [15:0] PROP_GAIN_RST  = 16'd512;
    localparam logic        [15:0] INTEG_GAIN_RST = 16'd2621;
    localparam logic        [14:0] DUTY_LIMIT_RST = 15'd1000;

    typedef struct packed {
        logic signed [15:0] speed_target;
        logic        [15:0] prop_gain;
        logic        [15:0] integ_gain;
        logic        [14:0] duty_limit;
    } cfg_t;

    typedef struct packed {
        logic                     fault;
        logic signed [ERR_W-1:0]  err;
        logic signed [PROD_W-1:0] p_prod;
        logic signed [PROD_W-1:0] i_prod;
    } prod_t;

endpackage

// ===== sv/pisl_in_if.sv =====
// ----------------------------------------------------------------------------
// pisl_in_if
// Sample channel: measured speed and bridge fault flag.
// ----------------------------------------------------------------------------
interface pisl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_speed;
    logic               bridge_fault;

    modport source (output valid, output measured_speed, output bridge_fault, input ready);
    modport sink   (input valid, input measured_speed, input bridge_fault, output ready);
endinterface

// ===== sv/pisl_out_if.sv =====
// ----------------------------------------------------------------------------
// pisl_out_if
// Result channel: drive duty and clamp state.
// ----------------------------------------------------------------------------
interface pisl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] duty;
    logic        [1:0]  clamp_state;

    modport source (output valid, output duty, output clamp_state, input ready);
    modport sink   (input valid, input duty, input clamp_state, output ready);
endinterface

// ===== sv/pisl_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pisl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pisl_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pisl_pkg::CFG_INDEX_W-1:0]   index;
    logic [pisl_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pisl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pisl_cfg_regs
// Configuration register file: setpoint, gains and duty limit.
// ----------------------------------------------------------------------------
module pisl_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    pisl_cfg_if.sink        cfg_wr,
    output pisl_pkg::cfg_t  cfg
);
    import pisl_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_wr.ready = 1'b1;
    assign cfg          = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                REG_SETPOINT:   cfg_next.speed_target = $signed(cfg_wr.data);
                REG_PROP_GAIN:  cfg_next.prop_gain    = cfg_wr.data;
                REG_INTEG_GAIN: cfg_next.integ_gain   = cfg_wr.data;
                REG_DUTY_LIMIT: cfg_next.duty_limit   = cfg_wr.data[14:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_target <= SETPOINT_RST;
            cfg_reg.prop_gain    <= PROP_GAIN_RST;
            cfg_reg.integ_gain   <= INTEG_GAIN_RST;
            cfg_reg.duty_limit   <= DUTY_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/pisl_prod_stage.sv =====
// ----------------------------------------------------------------------------
// pisl_prod_stage
// Input register, speed error and the two gain products.
// ----------------------------------------------------------------------------
module pisl_prod_stage (
    input  logic            clk,
    input  logic            rst_n,
    pisl_in_if.sink         sample,
    input  pisl_pkg::cfg_t  cfg,
    output logic            prod_valid,
    input  logic            prod_ready,
    output pisl_pkg::prod_t prod_word
);
    import pisl_pkg::*;

    logic               in_valid_reg;
    logic signed [15:0] meas_reg;
    logic               fault_reg;
    logic               prod_valid_reg;
    prod_t              prod_reg;
    prod_t              prod_next;
    logic               prod_move;
    logic               in_move;
    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W:0]   p_full;
    logic signed [PROD_W:0]   i_full;

    assign prod_move    = !prod_valid_reg || prod_ready;
    assign in_move      = !in_valid_reg || prod_move;
    assign sample.ready = in_move;
    assign prod_valid   = prod_valid_reg;
    assign prod_word    = prod_reg;

    always_comb
    begin
        err    = {cfg.speed_target[15], cfg.speed_target} - {meas_reg[15], meas_reg};
        p_full = $signed({1'b0, cfg.prop_gain}) * err;
        i_full = $signed({1'b0, cfg.integ_gain}) * err;
        prod_next.fault  = fault_reg;
        prod_next.err    = err;
        prod_next.p_prod = p_full[PROD_W-1:0];
        prod_next.i_prod = i_full[PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_move)
            begin
                in_valid_reg <= sample.valid;
            end
            if (prod_move)
            begin
                prod_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move && sample.valid)
        begin
            meas_reg  <= sample.measured_speed;
            fault_reg <= sample.bridge_fault;
        end
        if (prod_move && in_valid_reg)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ===== sv/pisl_integ_clamp.sv =====
// ----------------------------------------------------------------------------
// pisl_integ_clamp
// Integrator update with conditional integration, output clamp and
// result register.
// ----------------------------------------------------------------------------
module pisl_integ_clamp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            prod_valid,
    output logic            prod_ready,
    input  pisl_pkg::prod_t prod_word,
    input  pisl_pkg::cfg_t  cfg,
    pisl_out_if.source      result
);
    import pisl_pkg::*;

    localparam logic signed [SUM_W-1:0] INTEG_MAX = {2'b00, {(INTEG_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] INTEG_MIN = {2'b11, {(INTEG_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] FRAC_BIAS = 49'sd65535;

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic                      res_valid_reg;
    logic signed [15:0]        duty_reg;
    logic signed [15:0]        duty_next;
    clamp_state_t              cs_reg;
    clamp_state_t              cs_next;
    logic                      fire;
    logic signed [SUM_W-1:0]   tent_raw;
    logic signed [SUM_W-1:0]   tent;
    logic signed [SUM_W-1:0]   p_q16;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lim;
    logic signed [SUM_W-1:0]   biased;
    logic                      high;
    logic                      low;
    logic                      err_pos;
    logic                      err_neg;
    logic signed [15:0]        lim16;

    assign prod_ready         = !res_valid_reg || result.ready;
    assign fire               = prod_valid && prod_ready;
    assign result.valid       = res_valid_reg;
    assign result.duty        = duty_reg;
    assign result.clamp_state = cs_reg;

    always_comb
    begin
        tent_raw = {integ_reg[INTEG_W-1], integ_reg}
                 + {{(SUM_W-PROD_W){prod_word.i_prod[PROD_W-1]}}, prod_word.i_prod};
        if (tent_raw > INTEG_MAX)
            tent = INTEG_MAX;
        else if (tent_raw < INTEG_MIN)
            tent = INTEG_MIN;
        else
            tent = tent_raw;
        p_q16  = {{(SUM_W-PROD_W-8){prod_word.p_prod[PROD_W-1]}}, prod_word.p_prod, 8'b0};
        sum    = p_q16 + tent;
        lim    = {{(SUM_W-31){1'b0}}, cfg.duty_limit, 16'b0};
        high   = sum > lim;
        low    = sum < -lim;
        biased = sum + (sum[SUM_W-1] ? FRAC_BIAS : '0);
        lim16  = {1'b0, cfg.duty_limit};
        err_pos = !prod_word.err[ERR_W-1] && (prod_word.err != '0);
        err_neg = prod_word.err[ERR_W-1];

        if (prod_word.fault)
        begin
            duty_next  = '0;
            cs_next    = CS_FAULT;
            integ_next = '0;
        end
        else
        begin
            if (high)
            begin
                duty_next = lim16;
                cs_next   = CS_HIGH;
            end
            else if (low)
            begin
                duty_next = -lim16;
                cs_next   = CS_LOW;
            end
            else
            begin
                duty_next = biased[31:16];
                cs_next   = CS_NONE;
            end
            if ((high && err_pos) || (low && err_neg))
                integ_next = integ_reg;
            else
                integ_next = tent[INTEG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end
        else
        begin
            if (prod_ready)
            begin
                res_valid_reg <= prod_valid;
            end
            if (fire)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            duty_reg <= duty_next;
            cs_reg   <= cs_next;
        end
    end

    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && prod_word.fault |=> integ_reg == '0)
        else $error("integrator not cleared after fault word");

    a_integ_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(integ_reg))
        else $error("integrator moved without a word");

    a_high_rail: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && cs_reg == CS_HIGH |-> duty_reg == $signed({1'b0, cfg.duty_limit}))
        else $error("high clamp duty differs from limit");

    a_fault_duty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && cs_reg == CS_FAULT |-> duty_reg == '0)
        else $error("faulted word carries nonzero duty");

endmodule

// ===== sv/pi_speed_loop_antiwindup_core.sv =====
// ----------------------------------------------------------------------------
// pi_speed_loop_antiwindup_core
// Fixed-point PI speed controller with conditional-integration anti-windup.
// ----------------------------------------------------------------------------
// One sample word in, one result word out, one word per clock sustained
// while the result channel is ready. The edge that accepts the sample
// loads the input register; then the gain product register is loaded,
// and then the result register takes the integrator update and clamp.
// The integrator feedback closes within the last stage, so back-to-back
// samples see each other's integrator update. The user must write
// configuration through the cfg_wr channel only while no word is in flight;
// the block does not enforce it. Writes to an index above 3 are dropped.
// ----------------------------------------------------------------------------
module pi_speed_loop_antiwindup_core (
    input  logic        clk,
    input  logic        rst_n,
    pisl_cfg_if.sink    cfg_wr,
    pisl_in_if.sink     sample,
    pisl_out_if.source  result
);
    import pisl_pkg::*;

    cfg_t  cfg;
    prod_t prod_word;
    logic  prod_valid;
    logic  prod_ready;

    pisl_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg)
    );

    pisl_prod_stage u_prod_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .cfg        (cfg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_word  (prod_word)
    );

    pisl_integ_clamp u_integ_clamp (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_word  (prod_word),
        .cfg        (cfg),
        .result     (result)
    );

endmodule
